// File: sv/rrss_pkg.sv
// ============================================================================
// rrss_pkg
// Shared types, sizes and codes of the round-robin slice scheduler.
// ============================================================================
package rrss_pkg;

    // Number of slots in the job ring.
    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Field widths of the channels.
    localparam int ID_W   = 8;
    localparam int TIME_W = 16;
    localparam int STAT_W = 3;

    // Request codes.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SERVE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_SERVED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RETIRED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_ADDED   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

    // Payload of one slot in the data memory.
    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] slice;
    } slot_data_t;

    // Answer of the free slot search.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } free_slot_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD_LINK,
        ST_SRV_EXEC,
        ST_DONE
    } state_t;

endpackage

// File: sv/rrss_slot_ram.sv
// ============================================================================
// rrss_slot_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module rrss_slot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rrss_free_find.sv
// ============================================================================
// rrss_free_find
// Finds the lowest numbered free slot from the occupancy bits.
// ============================================================================
module rrss_free_find
    import rrss_pkg::*;
(
    input  logic [MAX_PROCS-1:0] slot_valid,
    output free_slot_t           free_slot
);

    // Scanning downward leaves the lowest free index as the final answer.
    always_comb begin
        free_slot = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (!slot_valid[i]) begin
                free_slot.found = 1'b1;
                free_slot.idx   = SLOT_W'(i);
            end
        end
    end

endmodule

// File: sv/round_robin_slice_scheduler_unit.sv
// ============================================================================
// round_robin_slice_scheduler_unit
// Round-robin time-slice scheduler over a linked ring of job slots.
// ============================================================================
// Usage: requests enter on the s_ channel (valid/ready). An add request
// appends a job (id, total time, slice) at the ring tail; a serve request
// visits the job under the cursor, charges its slice or retires it when no
// time is left, and advances the cursor. Every request gives exactly one
// result transfer on the m_ channel: a status, the visited job id, the time
// it has left and a flag for the last job of a round.
// Flow: a request is taken only while the sequencer is idle. A serve
// request and an add into a non-empty ring pass through accept, a memory
// step and the result hand-off; an add into an empty ring, a full ring or
// an empty serve go from accept straight to the hand-off. The memory step
// comes from the registered read of the slot memory and its single write
// port, which links the old tail in a step of its own.
// The hand-off loads the result into an output register once it is free.
// While the receiver stalls, the finished result waits in the hand-off
// state and the next request is held off. Reset (aresetn low, synchronous)
// empties the ring and drops any pending result; the slot memories need no
// clearing since an entry is always written before it is read.
// ============================================================================
module round_robin_slice_scheduler_unit
    import rrss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Request channel.
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [ID_W-1:0]   s_job_id,
    input  logic [TIME_W-1:0] s_total_time,
    input  logic [TIME_W-1:0] s_slice_time,
    // Result channel.
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [ID_W-1:0]   m_served_id,
    output logic [TIME_W-1:0] m_time_left,
    output logic              m_round_end
);

    localparam int DATA_W = $bits(slot_data_t);

    // Sequencer and ring pointers.
    state_t              state_reg, state_next;
    logic [MAX_PROCS-1:0] slot_valid_reg, slot_valid_next;
    logic [SLOT_W-1:0]   ring_head_reg, ring_head_next;
    logic [SLOT_W-1:0]   ring_tail_reg, ring_tail_next;
    logic [SLOT_W-1:0]   visit_cursor_reg, visit_cursor_next;
    logic [SLOT_W-1:0]   cursor_before_reg, cursor_before_next;
    logic [CNT_W-1:0]    job_count_reg, job_count_next;

    // Old tail and new slot of an add, for the second link write.
    logic [SLOT_W-1:0]   prev_tail_reg, prev_tail_next;
    logic [SLOT_W-1:0]   new_slot_reg, new_slot_next;

    // Result waiting for the output register.
    logic [STAT_W-1:0]   pend_status_reg, pend_status_next;
    logic [ID_W-1:0]     pend_id_reg, pend_id_next;
    logic [TIME_W-1:0]   pend_left_reg, pend_left_next;
    logic                pend_rend_reg, pend_rend_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_served_id_reg, m_served_id_next;
    logic [TIME_W-1:0]   m_time_left_reg, m_time_left_next;
    logic                m_round_end_reg, m_round_end_next;

    // Memory ports.
    logic                data_we, data_re;
    logic [SLOT_W-1:0]   data_waddr;
    slot_data_t          data_wdata, data_rdata;
    logic [DATA_W-1:0]   data_rdata_raw;
    logic                link_we;
    logic [SLOT_W-1:0]   link_waddr, link_wdata, link_rdata;

    // Decoded conditions.
    free_slot_t          free_slot;
    logic                in_xfer, out_xfer, out_free;
    logic                ring_full, ring_empty, add_ok;
    logic                cur_retire, cur_last, cur_is_tail;
    logic [TIME_W-1:0]   cur_new_rem;

    rrss_free_find u_free_find (
        .slot_valid (slot_valid_reg),
        .free_slot  (free_slot)
    );

    // Job id, remaining time and slice of each slot.
    rrss_slot_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_PROCS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (visit_cursor_reg),
        .rdata (data_rdata_raw)
    );

    // Ring successor of each slot.
    rrss_slot_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_PROCS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (data_re),
        .raddr (visit_cursor_reg),
        .rdata (link_rdata)
    );

    assign data_rdata = slot_data_t'(data_rdata_raw);

    assign in_xfer    = s_valid && s_ready;
    assign out_xfer   = m_valid_reg && m_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign ring_empty = (job_count_reg == '0);
    assign ring_full  = (job_count_reg == CNT_W'(MAX_PROCS)) || !free_slot.found;
    assign add_ok     = !ring_full;

    // The visited slot, as read from memory during the execute step.
    assign cur_retire  = (data_rdata.remaining == '0);
    assign cur_last    = (job_count_reg == CNT_W'(1));
    assign cur_is_tail = (visit_cursor_reg == ring_tail_reg);
    assign cur_new_rem = (data_rdata.remaining > data_rdata.slice)
                       ? (data_rdata.remaining - data_rdata.slice) : '0;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_req_type == REQ_ADD) begin
                        state_next = (add_ok && !ring_empty) ? ST_ADD_LINK : ST_DONE;
                    end else begin
                        state_next = ring_empty ? ST_DONE : ST_SRV_EXEC;
                    end
                end
            end
            ST_ADD_LINK: state_next = ST_DONE;
            ST_SRV_EXEC: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory controls of each state.
    always_comb begin
        s_ready    = 1'b0;
        data_we    = 1'b0;
        data_re    = 1'b0;
        data_waddr = free_slot.idx;
        data_wdata = '{job_id: s_job_id, remaining: s_total_time, slice: s_slice_time};
        link_we    = 1'b0;
        link_waddr = free_slot.idx;
        link_wdata = ring_empty ? free_slot.idx : ring_head_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (in_xfer) begin
                    if (s_req_type == REQ_ADD) begin
                        // New slot points back at the head (or itself).
                        data_we = add_ok;
                        link_we = add_ok;
                    end else begin
                        data_re = !ring_empty;
                    end
                end
            end
            ST_ADD_LINK: begin
                link_we    = 1'b1;
                link_waddr = prev_tail_reg;
                link_wdata = new_slot_reg;
            end
            ST_SRV_EXEC: begin
                data_waddr = visit_cursor_reg;
                data_wdata = '{job_id: data_rdata.job_id, remaining: cur_new_rem,
                               slice: data_rdata.slice};
                data_we    = !cur_retire;
                // Unlink a retired job from its predecessor.
                link_waddr = cursor_before_reg;
                link_wdata = link_rdata;
                link_we    = cur_retire && !cur_last;
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Ring pointers, occupancy and pending result.
    always_comb begin
        slot_valid_next    = slot_valid_reg;
        ring_head_next     = ring_head_reg;
        ring_tail_next     = ring_tail_reg;
        visit_cursor_next  = visit_cursor_reg;
        cursor_before_next = cursor_before_reg;
        job_count_next     = job_count_reg;
        prev_tail_next     = prev_tail_reg;
        new_slot_next      = new_slot_reg;
        pend_status_next   = pend_status_reg;
        pend_id_next       = pend_id_reg;
        pend_left_next     = pend_left_reg;
        pend_rend_next     = pend_rend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    pend_id_next   = '0;
                    pend_left_next = '0;
                    pend_rend_next = 1'b0;
                    if (s_req_type == REQ_ADD) begin
                        if (add_ok) begin
                            pend_status_next = STAT_ADDED;
                            slot_valid_next[free_slot.idx] = 1'b1;
                            job_count_next = job_count_reg + CNT_W'(1);
                            ring_tail_next = free_slot.idx;
                            prev_tail_next = ring_tail_reg;
                            new_slot_next  = free_slot.idx;
                            if (ring_empty) begin
                                ring_head_next     = free_slot.idx;
                                visit_cursor_next  = free_slot.idx;
                                cursor_before_next = free_slot.idx;
                            end else if (visit_cursor_reg == ring_head_reg) begin
                                // The new tail now sits just behind the cursor.
                                cursor_before_next = free_slot.idx;
                            end
                        end else begin
                            pend_status_next = STAT_FULL;
                        end
                    end else if (ring_empty) begin
                        pend_status_next = STAT_EMPTY;
                    end
                end
            end
            ST_SRV_EXEC: begin
                pend_id_next   = data_rdata.job_id;
                pend_rend_next = cur_is_tail;
                if (cur_retire) begin
                    pend_status_next = STAT_RETIRED;
                    pend_left_next   = '0;
                    slot_valid_next[visit_cursor_reg] = 1'b0;
                    if (cur_last) begin
                        job_count_next     = '0;
                        ring_head_next     = '0;
                        ring_tail_next     = '0;
                        visit_cursor_next  = '0;
                        cursor_before_next = '0;
                    end else begin
                        job_count_next    = job_count_reg - CNT_W'(1);
                        visit_cursor_next = link_rdata;
                        if (visit_cursor_reg == ring_head_reg) begin
                            ring_head_next = link_rdata;
                        end
                        if (cur_is_tail) begin
                            ring_tail_next = cursor_before_reg;
                        end
                    end
                end else begin
                    pend_status_next   = STAT_SERVED;
                    pend_left_next     = cur_new_rem;
                    cursor_before_next = visit_cursor_reg;
                    visit_cursor_next  = link_rdata;
                end
            end
            ST_ADD_LINK: begin
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded from the pending result once it is free.
    always_comb begin
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_served_id_next = m_served_id_reg;
        m_time_left_next = m_time_left_reg;
        m_round_end_next = m_round_end_reg;
        if (out_xfer) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next     = 1'b1;
            m_status_next    = pend_status_reg;
            m_served_id_next = pend_id_reg;
            m_time_left_next = pend_left_reg;
            m_round_end_next = pend_rend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            slot_valid_reg    <= '0;
            ring_head_reg     <= '0;
            ring_tail_reg     <= '0;
            visit_cursor_reg  <= '0;
            cursor_before_reg <= '0;
            job_count_reg     <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            slot_valid_reg    <= slot_valid_next;
            ring_head_reg     <= ring_head_next;
            ring_tail_reg     <= ring_tail_next;
            visit_cursor_reg  <= visit_cursor_next;
            cursor_before_reg <= cursor_before_next;
            job_count_reg     <= job_count_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_tail_reg   <= prev_tail_next;
        new_slot_reg    <= new_slot_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        pend_left_reg   <= pend_left_next;
        pend_rend_reg   <= pend_rend_next;
        m_status_reg    <= m_status_next;
        m_served_id_reg <= m_served_id_next;
        m_time_left_reg <= m_time_left_next;
        m_round_end_reg <= m_round_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_served_id = m_served_id_reg;
    assign m_time_left = m_time_left_reg;
    assign m_round_end = m_round_end_reg;

    // The job count always matches the number of occupied slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(slot_valid_reg) == int'(job_count_reg))
        else $error("job count differs from slot occupancy");

    // An empty ring has all of its pointers back at slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (job_count_reg == '0) |-> (ring_head_reg == '0 && ring_tail_reg == '0
                                   && visit_cursor_reg == '0))
        else $error("empty ring with stray pointers");

    // A serve only ever visits an occupied slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRV_EXEC) |-> slot_valid_reg[visit_cursor_reg])
        else $error("serve visits a free slot");

    // Every request transfer produces a result in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> m_valid_reg)
        else $error("result lost at hand-off");

endmodule
